@@ rtl/bdrs_pkg.sv @@
package bdrs_pkg;

  // Width of the random words as delivered by the source
  localparam int RAND_BITS = 16;
  localparam logic [15:0] RAND_MASK = 16'((64'd1 << RAND_BITS) - 64'd1);

  // Pipeline depth, input register to output register
  localparam int NUM_STAGES = 17;

  // Fixed-point constants
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // Reciprocals for constant division, scaled by 2^34
  localparam logic [31:0] RECIP_42 = 32'(64'h4_0000_0000 / 42);
  localparam logic [31:0] RECIP_30 = 32'(64'h4_0000_0000 / 30);
  localparam logic [31:0] RECIP_20 = 32'(64'h4_0000_0000 / 20);
  localparam logic [31:0] RECIP_12 = 32'(64'h4_0000_0000 / 12);
  localparam logic [31:0] RECIP_6  = 32'(64'h4_0000_0000 / 6);
  localparam logic [5:0]  DIV_42 = 6'd42;
  localparam logic [5:0]  DIV_30 = 6'd30;
  localparam logic [5:0]  DIV_20 = 6'd20;
  localparam logic [5:0]  DIV_12 = 6'd12;
  localparam logic [5:0]  DIV_6  = 6'd6;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ASYMMETRY = 2'd0,
    CFG_ENDPOINT  = 2'd1,
    CFG_MAX_PROB  = 2'd2,
    CFG_VTX_HALF  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] rand_cos;
    logic [15:0] rand_energy;
    logic [15:0] rand_phi;
    logic [15:0] rand_accept;
    logic [15:0] rand_vertex;
  } in_beat_t;

  typedef struct packed {
    logic               accepted;
    logic [15:0]        kinetic_energy;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] vertex_z_mm;
  } out_beat_t;

  typedef struct packed {
    logic signed [14:0] asym;
    logic [14:0]        w0;
    logic [19:0]        maxp;
    logic [14:0]        half;
  } cfg_t;

  // Square root iteration state
  typedef struct packed {
    logic [30:0] v;
    logic [30:0] res;
  } sq_t;

  // Everything one trial carries down the pipeline
  typedef struct packed {
    logic signed [15:0] cth;
    logic [15:0]        ue;
    logic [15:0]        ua;
    logic [15:0]        uv;
    logic [2:0]         oct;
    logic [13:0]        rph;
    logic [14:0]        w;
    logic [19:0]        env;
    logic [15:0]        zq;
    logic [15:0]        vz;
    logic [28:0]        cth2;
    logic [29:0]        x;
    logic [29:0]        x2;
    sq_t                p;
    sq_t                s;
    logic [17:0]        dd;
    logic [15:0]        ke;
    logic [29:0]        qs;
    logic [29:0]        qc;
    logic [29:0]        ms;
    logic [29:0]        mc;
    logic [30:0]        sacc;
    logic [30:0]        cacc;
    logic [17:0]        pw;
    logic [23:0]        shape;
    logic [15:0]        rem;
    logic [13:0]        beta;
    logic signed [15:0] sphi;
    logic signed [15:0] cphi;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] t;
    logic [15:0]        corr;
    logic [25:0]        prob;
    logic               acc;
  } work_t;

  // Random word to Q0.16 fraction
  function automatic logic [15:0] frac16(input logic [15:0] r);
    logic [47:0] v;
    v = {32'd0, r & RAND_MASK} << (32 - RAND_BITS);
    return v[31:16];
  endfunction

endpackage

@@ rtl/beta_decay_rejection_sampler.sv @@
// Beta decay rejection trial generator.
// Input channel (in_valid/in_ready/in_data): one beat is one trial made of
// five uniform random words. Result channel (out_valid/out_ready/out_data):
// exactly one beat per trial, in order, carrying the accept flag, kinetic
// energy, unit direction and vertex z; rejected trials are still delivered.
// Configuration port (cfg_we/cfg_index/cfg_data): single-cycle register
// writes, to be done while no trial is in flight.
// Path: a trial accepted at the input is carried through stage registers
// 0 to 16 to the output. Throughput: one trial per cycle while out_ready
// is high, set by the 17-stage pipeline in which both square roots, the
// beta divider and the sine/cosine series run a few steps per stage.
// Reset: clears all stage valid bits and loads the default register values.
// Stall: when out_ready is low, beats collapse into empty stages so input
// keeps flowing until every stage is full; nothing is dropped or repeated.
module beta_decay_rejection_sampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdrs_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bdrs_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  import bdrs_pkg::*;

  cfg_t  cfg_r;
  work_t in_w;
  work_t src [NUM_STAGES];
  work_t st_nxt [NUM_STAGES];
  work_t st_r [NUM_STAGES];
  logic  [NUM_STAGES-1:0] v_r;
  logic  [NUM_STAGES:0]   en;
  logic  [15:0] uc_w;
  logic  [15:0] up_w;

  // One square root step, bit position taken from the step number
  function automatic sq_t sqrt_step(input sq_t a, input int i);
    sq_t         b;
    logic [30:0] bt;
    logic [30:0] rb;
    b  = a;
    bt = 31'd1 << (28 - 2 * i);
    rb = a.res + bt;
    if (a.v >= rb) begin
      b.v   = a.v - rb;
      b.res = (a.res >> 1) + bt;
    end else begin
      b.res = a.res >> 1;
    end
    return b;
  endfunction

  // Q0.30 product
  function automatic logic [29:0] mul30(input logic [29:0] n, input logic [30:0] s);
    logic [63:0] m;
    m = 64'(n) * 64'(s);
    return m[59:30];
  endfunction

  // Quotient estimate, low by at most one
  function automatic logic [29:0] div_est(input logic [29:0] n, input logic [31:0] rc);
    logic [63:0] m;
    m = 64'(n) * 64'(rc);
    return m[63:34];
  endfunction

  // Quotient correction
  function automatic logic [29:0] div_fix(input logic [29:0] n, input logic [29:0] q0,
                                          input logic [5:0] d);
    logic [35:0] pr;
    logic [35:0] rm;
    pr = 36'(q0) * 36'(d);
    rm = 36'(n) - pr;
    return (rm >= 36'(d)) ? q0 + 30'd1 : q0;
  endfunction

  // Combinational work of stage k
  function automatic work_t stage_fn(input int k, input work_t a, input cfg_t c);
    work_t              b;
    logic [63:0]        m0;
    logic [63:0]        m1;
    logic [63:0]        m2;
    logic [63:0]        m3;
    logic [63:0]        m4;
    logic signed [63:0] sm0;
    logic signed [63:0] sm1;
    logic [14:0]        span;
    logic [14:0]        d;
    logic [16:0]        tr;
    logic [16:0]        wz;
    logic [16:0]        zt;
    logic signed [15:0] s0;
    logic signed [15:0] c0;
    int                 i;
    b = a;

    // Square roots for momentum and sin(theta), three steps a stage
    if (k >= 3 && k <= 7) begin
      for (int j = 0; j < 3; j++) begin
        i = 3 * (k - 3) + j;
        b.p = sqrt_step(b.p, i);
        b.s = sqrt_step(b.s, i);
      end
    end

    // Restoring divider for beta = p * 2^14 / W, three bits a stage
    if (k >= 8 && k <= 12) begin
      if (k == 8) begin
        b.rem  = {1'b0, a.p.res[14:0]};
        b.beta = '0;
      end
      wz = {2'b0, a.w};
      for (int j = 0; j < 3; j++) begin
        i = 3 * (k - 8) + j;
        if (i < 14) begin
          tr = {b.rem, 1'b0};
          if (tr >= wz) begin
            tr     = tr - wz;
            b.beta = {b.beta[12:0], 1'b1};
          end else begin
            b.beta = {b.beta[12:0], 1'b0};
          end
          b.rem = tr[15:0];
        end
      end
    end

    case (k)
      1: begin
        // Energy draw, envelope, vertex, cos^2 and phase angle
        span  = (c.w0 > 15'd4096) ? c.w0 - 15'd4096 : '0;
        m0    = 64'(span) * 64'(a.ue);
        b.w   = 15'd4096 + m0[30:16];
        m1    = 64'(c.maxp) * 64'(a.ua);
        b.env = m1[35:16];
        m2    = 64'({c.half, 1'b0}) * 64'(a.uv);
        b.zq  = m2[31:16];
        sm0   = 64'(a.cth) * 64'(a.cth);
        b.cth2 = sm0[28:0];
        m3    = 64'(a.rph) * TWO_PI_Q30;
        b.x   = m3[45:16];
      end
      2: begin
        // Square root operands, (W0-W)^2, kinetic energy, vertex, x^2
        m0    = 64'(a.w) * 64'(a.w) - 64'd16777216;
        b.p.v = m0[30:0];
        b.p.res = '0;
        m1    = 64'd268435456 - 64'(a.cth2);
        b.s.v = m1[30:0];
        b.s.res = '0;
        d     = (c.w0 > a.w) ? c.w0 - a.w : '0;
        m2    = 64'(d) * 64'(d);
        b.dd  = m2[29:12];
        m3    = 64'(a.w - 15'd4096) * 64'd511;
        b.ke  = (m3[63:24] != '0) ? 16'hFFFF : m3[23:8];
        zt    = {1'b0, a.zq} - {2'b0, c.half};
        b.vz  = zt[15:0];
        m4    = 64'(a.x) * 64'(a.x);
        b.x2  = m4[59:30];
      end
      3: begin
        b.qs = div_est(a.x2, RECIP_42);
        b.qc = div_est(a.x2, RECIP_30);
      end
      4: begin
        b.sacc = ONE_Q30 - {1'b0, div_fix(a.x2, a.qs, DIV_42)};
        b.cacc = ONE_Q30 - {1'b0, div_fix(a.x2, a.qc, DIV_30)};
      end
      5: begin
        b.ms = mul30(a.x2, a.sacc);
        b.mc = mul30(a.x2, a.cacc);
      end
      6: begin
        b.qs = div_est(a.ms, RECIP_20);
        b.qc = div_est(a.mc, RECIP_12);
      end
      7: begin
        b.sacc = ONE_Q30 - {1'b0, div_fix(a.ms, a.qs, DIV_20)};
        b.cacc = ONE_Q30 - {1'b0, div_fix(a.mc, a.qc, DIV_12)};
      end
      8: begin
        b.ms = mul30(a.x2, a.sacc);
        b.mc = mul30(a.x2, a.cacc);
        m0   = 64'(a.p.res[14:0]) * 64'(a.w);
        b.pw = m0[29:12];
      end
      9: begin
        b.qs    = div_est(a.ms, RECIP_6);
        b.cacc  = ONE_Q30 - {2'b0, a.mc[29:1]};
        m0      = 64'(a.pw) * 64'(a.dd);
        b.shape = m0[35:12];
      end
      10: begin
        b.sacc = ONE_Q30 - {1'b0, div_fix(a.ms, a.qs, DIV_6)};
      end
      11: begin
        b.ms = mul30(a.x, a.sacc);
      end
      12: begin
        // Round to Q1.14 and unfold the octant
        m0 = 64'(a.ms) + 64'd32768;
        m1 = 64'(a.cacc) + 64'd32768;
        s0 = $signed({1'b0, m0[30:16]});
        c0 = $signed({1'b0, m1[30:16]});
        case (a.oct)
          3'd0: begin b.sphi = s0;  b.cphi = c0;  end
          3'd1: begin b.sphi = c0;  b.cphi = s0;  end
          3'd2: begin b.sphi = c0;  b.cphi = -s0; end
          3'd3: begin b.sphi = s0;  b.cphi = -c0; end
          3'd4: begin b.sphi = -s0; b.cphi = -c0; end
          3'd5: begin b.sphi = -c0; b.cphi = -s0; end
          3'd6: begin b.sphi = -c0; b.cphi = s0;  end
          default: begin b.sphi = -s0; b.cphi = c0; end
        endcase
      end
      13: begin
        // A*beta and the transverse direction components
        sm0  = 64'(c.asym) * 64'($signed({1'b0, a.beta}));
        sm0  = sm0 >>> 14;
        b.t  = sm0[15:0];
        sm1  = 64'(a.cphi) * 64'($signed({1'b0, a.s.res[14:0]})) + 64'sd8192;
        sm1  = sm1 >>> 14;
        b.dx = sm1[15:0];
        sm1  = 64'(a.sphi) * 64'($signed({1'b0, a.s.res[14:0]})) + 64'sd8192;
        sm1  = sm1 >>> 14;
        b.dy = sm1[15:0];
      end
      14: begin
        // Correlation factor, clamped at zero
        sm0    = 64'(a.t) * 64'(a.cth);
        sm0    = (sm0 >>> 14) + 64'sd16384;
        b.corr = (sm0 < 0) ? '0 : sm0[15:0];
      end
      15: begin
        m0     = 64'(a.shape) * 64'(a.corr);
        b.prob = m0[39:14];
      end
      16: begin
        b.acc = ({6'd0, a.env} <= a.prob);
      end
      default: begin
        b = a;
      end
    endcase
    return b;
  endfunction

  // Input beat unpacked into the first stage
  always_comb begin
    in_w     = '0;
    uc_w     = frac16(in_data.rand_cos);
    up_w     = frac16(in_data.rand_phi);
    in_w.cth = $signed({1'b0, uc_w[15:1]} - 16'd16384);
    in_w.ue  = frac16(in_data.rand_energy);
    in_w.ua  = frac16(in_data.rand_accept);
    in_w.uv  = frac16(in_data.rand_vertex);
    in_w.oct = up_w[15:13];
    in_w.rph = up_w[13] ? 14'd8192 - {1'b0, up_w[12:0]} : {1'b0, up_w[12:0]};
  end

  // Stage inputs and next values
  always_comb begin
    src[0] = in_w;
    for (int k = 1; k < NUM_STAGES; k++) begin
      src[k] = st_r[k-1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      st_nxt[k] = stage_fn(k, src[k], cfg_r);
    end
  end

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.asym <= -15'sd1925;
      cfg_r.w0   <= 15'd10364;
      cfg_r.maxp <= 20'd8022;
      cfg_r.half <= 15'd1500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ASYMMETRY: cfg_r.asym <= $signed(cfg_data[14:0]);
        CFG_ENDPOINT:  cfg_r.w0   <= cfg_data[14:0];
        CFG_MAX_PROB:  cfg_r.maxp <= cfg_data;
        CFG_VTX_HALF:  cfg_r.half <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Result beat
  assign out_valid               = v_r[NUM_STAGES-1];
  assign out_data.accepted       = st_r[NUM_STAGES-1].acc;
  assign out_data.kinetic_energy = st_r[NUM_STAGES-1].ke;
  assign out_data.dir_x          = st_r[NUM_STAGES-1].dx;
  assign out_data.dir_y          = st_r[NUM_STAGES-1].dy;
  assign out_data.dir_z          = st_r[NUM_STAGES-1].cth;
  assign out_data.vertex_z_mm    = st_r[NUM_STAGES-1].vz;

endmodule

@@ sim/tb.sv @@
module tb;
  import bdrs_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ASYMMETRY;
  logic [19:0] cfg_data = '0;

  beta_decay_rejection_sampler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers
  logic signed [14:0] m_asym;
  logic [14:0]        m_w0;
  logic [19:0]        m_maxp;
  logic [14:0]        m_half;

  in_beat_t  trial_q[$];
  out_beat_t expected_trials[$];
  int        errors = 0;
  int        cycles = 0;
  bit        feeding_done = 1'b0;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;  // arithmetic shift is floor for two's complement
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned to_frac(logic [15:0] r);
    return longint'(r);  // 16-bit randoms map straight to Q0.16
  endfunction

  // Sine and cosine of a 16-bit phase, Q1.14 rounded
  function automatic void phase_sincos(longint unsigned ph, output longint sn,
                                       output longint cs);
    int unsigned oct;
    longint unsigned r, x, x2, s, c;
    longint s0, c0;
    oct = (ph >> 13) & 7;
    r = ph & 16'h1FFF;
    if (oct[0]) r = 8192 - r;
    x = (r * 64'd6746518852) >> 16;
    x2 = (x * x) >> 30;
    s = (64'd1 << 30) - x2 / 42;
    s = (64'd1 << 30) - ((x2 * s) >> 30) / 20;
    s = (64'd1 << 30) - ((x2 * s) >> 30) / 6;
    s = (x * s) >> 30;
    c = (64'd1 << 30) - x2 / 30;
    c = (64'd1 << 30) - ((x2 * c) >> 30) / 12;
    c = (64'd1 << 30) - ((x2 * c) >> 30) / 2;
    s0 = longint'((s + 32768) >> 16);
    c0 = longint'((c + 32768) >> 16);
    case (oct)
      0: begin sn = s0;  cs = c0;  end
      1: begin sn = c0;  cs = s0;  end
      2: begin sn = c0;  cs = -s0; end
      3: begin sn = s0;  cs = -c0; end
      4: begin sn = -s0; cs = -c0; end
      5: begin sn = -c0; cs = -s0; end
      6: begin sn = -c0; cs = s0;  end
      default: begin sn = -s0; cs = c0; end
    endcase
  endfunction

  // One rejection trial
  function automatic out_beat_t trial_result(in_beat_t b);
    out_beat_t o;
    longint unsigned ue, ua, uv, span, w, p, d, shape, prob, env, ke, w0;
    longint cth, beta, t, corr, sth, sphi, cphi, z, asym, half;
    w0 = m_w0;
    asym = m_asym;
    half = m_half;
    cth = -16384 + longint'(to_frac(b.rand_cos) >> 1);
    ue = to_frac(b.rand_energy);
    ua = to_frac(b.rand_accept);
    uv = to_frac(b.rand_vertex);
    span = (w0 > 4096) ? w0 - 4096 : 0;
    w = 4096 + ((span * ue) >> 16);
    p = int_sqrt(w * w - (64'd1 << 24));
    d = (w0 > w) ? w0 - w : 0;
    shape = (((p * w) >> 12) * ((d * d) >> 12)) >> 12;
    beta = longint'((p << 14) / w);
    t = floor_shift(asym * beta, 14);
    corr = 16384 + floor_shift(t * cth, 14);
    if (corr < 0) corr = 0;
    prob = (shape * longint'(corr)) >> 14;
    env = (longint'(m_maxp) * ua) >> 16;
    ke = ((w - 4096) * 511) >> 8;
    if (ke > 65535) ke = 65535;
    sth = longint'(int_sqrt((64'd1 << 28) - longint'(cth * cth)));
    phase_sincos(to_frac(b.rand_phi), sphi, cphi);
    z = -half + longint'((2 * longint'(m_half) * uv) >> 16);
    o.accepted = (env <= prob);
    o.kinetic_energy = ke[15:0];
    o.dir_x = 16'(floor_shift(cphi * sth + 8192, 14));
    o.dir_y = 16'(floor_shift(sphi * sth + 8192, 14));
    o.dir_z = 16'(cth);
    o.vertex_z_mm = 16'(z);
    return o;
  endfunction

  int in_gap = 0;

  bit in_taken;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) expected_trials.push_back(trial_result(in_data));
    // Monitor
    if (out_valid && out_ready) begin
      if (expected_trials.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        errors++;
      end else begin
        out_beat_t e;
        e = expected_trials.pop_front();
        if (e.accepted !== out_data.accepted)
          $display("%0t: accepted exp %0d got %0d", $time, e.accepted, out_data.accepted);
        if (e.kinetic_energy !== out_data.kinetic_energy)
          $display("%0t: kinetic_energy exp %0d got %0d", $time, e.kinetic_energy,
                   out_data.kinetic_energy);
        if (e.dir_x !== out_data.dir_x)
          $display("%0t: dir_x exp %0d got %0d", $time, e.dir_x, out_data.dir_x);
        if (e.dir_y !== out_data.dir_y)
          $display("%0t: dir_y exp %0d got %0d", $time, e.dir_y, out_data.dir_y);
        if (e.dir_z !== out_data.dir_z)
          $display("%0t: dir_z exp %0d got %0d", $time, e.dir_z, out_data.dir_z);
        if (e.vertex_z_mm !== out_data.vertex_z_mm)
          $display("%0t: vertex_z_mm exp %0d got %0d", $time, e.vertex_z_mm,
                   out_data.vertex_z_mm);
        if (e !== out_data) errors++;
      end
    end
    if (cycles > 400000) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Input side: after an accepted beat, draw a gap, then offer the next one
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_taken || !in_valid) begin
      if (in_taken && in_gap == 0) in_gap = (($urandom_range(0, 3) == 0) ? 0 :
                                             $urandom_range(0, 13));
      if (in_gap > 0 && !(in_taken && in_valid && trial_q.size() == 0)) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (trial_q.size() > 0) begin
        in_data <= trial_q.pop_front();
        in_valid <= 1'b1;
        in_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random ready stalls, sometimes none at all
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap = $urandom_range(0, 13);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ASYMMETRY: m_asym = val[14:0];
      CFG_ENDPOINT:  m_w0 = val[14:0];
      CFG_MAX_PROB:  m_maxp = val;
      default:       m_half = val[14:0];
    endcase
  endtask

  task automatic drain();
    while (trial_q.size() > 0 || in_valid || expected_trials.size() > 0) @(negedge clk);
    repeat (NUM_STAGES + 4) @(negedge clk);
  endtask

  function automatic in_beat_t rand_trial();
    in_beat_t b;
    b = 80'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) == 0) b.rand_cos = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
    if ($urandom_range(0, 9) == 0) b.rand_energy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
    // keep a good share of trials in the accepting region
    if ($urandom_range(0, 2) == 0) b.rand_accept = 16'($urandom_range(0, 255));
    return b;
  endfunction

  initial begin
    in_beat_t b;
    m_asym = -15'sd1925;
    m_w0 = 15'd10364;
    m_maxp = 20'd8022;
    m_half = 15'd1500;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes under reset settings
    trial_q.push_back('0);
    trial_q.push_back('1);
    trial_q.push_back({16'h8000, 16'h8000, 16'h2000, 16'h0, 16'h8000});
    for (int k = 0; k < 8; k++)
      trial_q.push_back({16'h4000, 16'h4000, 16'(k * 16'h2000 + 16'h0800), 16'h0, 16'h0});
    trial_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();

    // Endpoint just above one (span of one) and the largest endpoint
    write_reg(CFG_ENDPOINT, 20'd4097);
    trial_q.push_back({16'h1234, 16'hFFFF, 16'h4321, 16'h0, 16'h7FFF});
    trial_q.push_back({16'h0, 16'h8000, 16'h0, 16'h1, 16'h0});
    drain();
    write_reg(CFG_ENDPOINT, 20'd32767);
    write_reg(CFG_ASYMMETRY, 20'h04000);
    write_reg(CFG_MAX_PROB, 20'hFFFFF);
    write_reg(CFG_VTX_HALF, 20'd32767);
    trial_q.push_back('1);
    trial_q.push_back({16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0});
    trial_q.push_back({16'hFFFF, 16'h8000, 16'h0, 16'h8000, 16'h8000});
    drain();

    // Random phases through several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_ASYMMETRY, 20'h03FFF);
          write_reg(CFG_MAX_PROB, 20'd1);
          write_reg(CFG_VTX_HALF, 20'd0);
          write_reg(CFG_ENDPOINT, 20'd4097);
        end
        default: begin
          write_reg(CFG_ASYMMETRY, 20'($urandom_range(0, 32767)));
          write_reg(CFG_ENDPOINT, 20'($urandom_range(4097, 32767)));
          write_reg(CFG_MAX_PROB, 20'($urandom_range(1, 20000)));
          write_reg(CFG_VTX_HALF, 20'($urandom_range(0, 32767)));
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        b = rand_trial();
        trial_q.push_back(b);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/bdrs_pkg.sv
rtl/beta_decay_rejection_sampler.sv
sim/tb.sv
